FILE: rtl/wrgrm_pkg.sv
// ============================================================================
// wrgrm_pkg: shared types and constants of the gain-reduction meter
// Holds register indexes, widths, limits and the sequencer state type.
// ============================================================================
package wrgrm_pkg;

    localparam int SampleBits   = 24;
    localparam int LatBits      = 12;
    localparam int WinBits      = 17;
    localparam int ThrBits      = 21;
    localparam int GainBits     = 18;
    localparam int LogFracBits  = 24;
    localparam int LogBits      = 6 + LogFracBits;  // unsigned log2 in Q6.24

    localparam logic [1:0] REG_WINDOW_LEN = 2'd0;
    localparam logic [1:0] REG_LATENCY    = 2'd1;
    localparam logic [1:0] REG_SILENCE    = 2'd2;

    localparam logic [WinBits-1:0]  MaxWindow  = 17'd65536;
    localparam logic [GainBits-1:0] GainFloor  = 18'sh2D400;   // -76800
    localparam logic [GainBits-1:0] GainCeil   = 18'd32767;
    localparam logic [17:0]         DbPerOct   = 18'd197283;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_ACCUM,
        ST_THRESH,
        ST_LOG_START,
        ST_LOG_NORM,
        ST_LOG_SQ,
        ST_LOG_STEP,
        ST_SCALE,
        ST_ROUND,
        ST_EMIT
    } state_t;

endpackage

FILE: rtl/windowed_rms_gain_reduction_meter.sv
// ============================================================================
// windowed_rms_gain_reduction_meter: windowed wet/dry level meter
// Pairs delayed dry samples with wet samples, sums energies over windows and
// reports the wet/dry level in signed Q10.7 dB at each window end.
// ============================================================================
// The block takes one word of a dry and a wet sample at a time. The dry
// sample is written into a 4096-entry delay memory, and the delayed dry sample
// is read back from the same memory in the following cycle. While the first
// latency_samples words are still filling the delay line, a word is only
// stored and the next word can be accepted in the following cycle. An ordinary
// paired word passes through the read and accumulate states before the next
// word is accepted. A word that closes a silent window, or a window with no
// wet energy, passes also through the threshold and emit states. Any other
// window end works out two base-2 logarithms on one shared squaring unit, 24
// fraction bits a logarithm: a normalization state, then a squaring and a
// step state per bit; scale and round follow. The result is held in an output
// register until taken; the next words may be accepted while it waits, but
// the next window end stalls until the held word has left. Delay memory
// entries never written read back as whatever the memory holds; the first
// latency_samples words after reset never pair, so such entries are not used.
module windowed_rms_gain_reduction_meter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [23:0] dry_sample, [47:24] wet_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [17:0] gain_db, [49:18] window_start,
                                   // [50] silent, [55:51] zero
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [20:0] cfg_wdata
);

    localparam int SB = wrgrm_pkg::SampleBits;
    localparam int LB = wrgrm_pkg::LatBits;
    localparam int WB = wrgrm_pkg::WinBits;
    localparam int FB = wrgrm_pkg::LogFracBits;
    localparam int GB_W = wrgrm_pkg::GainBits;

    // Configuration registers.
    logic [WB-1:0] win_reg;
    logic [LB-1:0] lat_reg;
    logic [20:0]   thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= 17'd480;
            lat_reg <= '0;
            thr_reg <= 21'd70;
        end else if (cfg_we) begin
            case (cfg_index)
                wrgrm_pkg::REG_WINDOW_LEN: win_reg <= cfg_wdata[WB-1:0];
                wrgrm_pkg::REG_LATENCY:    lat_reg <= cfg_wdata[LB-1:0];
                wrgrm_pkg::REG_SILENCE:    thr_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective window length: zero means one, above the limit saturates.
    logic [WB-1:0] win_eff;
    always_comb begin
        win_eff = win_reg;
        if (win_reg == '0) begin
            win_eff = 17'd1;
        end else if (win_reg > wrgrm_pkg::MaxWindow) begin
            win_eff = wrgrm_pkg::MaxWindow;
        end
    end

    // Dry delay memory, one write and one registered read per cycle.
    logic [SB-1:0] dly_mem [0:(1<<LB)-1];
    logic [SB-1:0] dly_rd_reg;
    logic          mem_we;
    logic [LB-1:0] mem_rd_addr;
    logic [LB-1:0] wpos_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            dly_mem[wpos_reg] <= s_tdata[SB-1:0];
        end
        dly_rd_reg <= dly_mem[mem_rd_addr];
    end

    // The read that matters happens in the cycle after the write, when the
    // write position has already moved on by one.
    assign mem_rd_addr = wpos_reg - lat_reg - 1'b1;

    // Datapath state.
    wrgrm_pkg::state_t state_reg, state_next;
    logic [12:0]   seen_reg;
    logic [WB-1:0] pairs_reg;
    logic [63:0]   dry_e_reg, wet_e_reg;
    logic [31:0]   nws_reg;
    logic [SB-1:0] wet_s_reg;
    logic          silent_reg;
    logic          which_reg;      // 0 = wet logarithm, 1 = dry logarithm
    logic [31:0]   mant_reg;
    logic [63:0]   sq_reg;
    logic [4:0]    bit_reg;
    logic [29:0]   lw_reg, lg_reg;
    logic signed [48:0] prod_reg;
    logic [GB_W-1:0] gain_reg;
    logic          m_valid_reg;
    logic [55:0]   m_data_reg;

    // Magnitudes and squares; one 24x24 multiply each, registered after.
    function automatic logic [SB-1:0] mag_of(input logic [SB-1:0] v);
        mag_of = v[SB-1] ? (~v + 1'b1) : v;
    endfunction

    logic [SB-1:0] dmag, wmag;
    logic [47:0]   dprod, wprod;
    logic [63:0]   dsq, wsq;
    logic [64:0]   dsum, wsum;
    assign dmag  = mag_of(dly_rd_reg);
    assign wmag  = mag_of(wet_s_reg);
    assign dprod = dmag * dmag;
    assign wprod = wmag * wmag;
    assign dsq   = {16'd0, dprod};
    assign wsq   = {16'd0, wprod};
    assign dsum  = {1'b0, dry_e_reg} + {1'b0, dsq};
    assign wsum  = {1'b0, wet_e_reg} + {1'b0, wsq};

    // Silence threshold product, 21x17 bits.
    logic [37:0] thr_prod;
    assign thr_prod = thr_reg * pairs_reg;

    // Leading-one position of the value under the logarithm.
    logic [63:0] log_x;
    logic [5:0]  lead;
    assign log_x = which_reg ? dry_e_reg : wet_e_reg;
    always_comb begin
        lead = '0;
        for (int i = 0; i < 64; i++) begin
            if (log_x[i]) begin
                lead = 6'(i);
            end
        end
    end

    // Normalized mantissa in Q1.31.
    logic [31:0] norm_m;
    always_comb begin
        logic [63:0] sh;
        sh = log_x << (6'd63 - lead);
        norm_m = sh[63:32];
    end

    logic signed [30:0] ldiff;
    assign ldiff = $signed({1'b0, lw_reg}) - $signed({1'b0, lg_reg});

    logic [48:0] pmag;
    logic [17:0] qmag;
    logic signed [18:0] gsig;
    always_comb begin
        pmag = prod_reg[48] ? 49'(-prod_reg) : 49'(prod_reg);
        qmag = 18'((pmag + 49'(64'h8000_0000)) >> 32);
        gsig = prod_reg[48] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    end

    logic accept_in;
    assign accept_in = s_tvalid && s_tready;
    assign s_tready  = (state_reg == wrgrm_pkg::ST_IDLE);
    assign mem_we    = accept_in;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wrgrm_pkg::ST_IDLE:
                if (accept_in) begin
                    state_next = (13'(lat_reg) > seen_reg) ? wrgrm_pkg::ST_IDLE
                                                           : wrgrm_pkg::ST_READ;
                end
            wrgrm_pkg::ST_READ:   state_next = wrgrm_pkg::ST_ACCUM;
            wrgrm_pkg::ST_ACCUM:
                state_next = (pairs_reg + 1'b1 >= win_eff) ? wrgrm_pkg::ST_THRESH
                                                           : wrgrm_pkg::ST_IDLE;
            wrgrm_pkg::ST_THRESH:
                if (m_valid_reg && !m_tready) begin
                    state_next = wrgrm_pkg::ST_THRESH;
                end else if (dry_e_reg == '0 || dry_e_reg < 64'(thr_prod)) begin
                    state_next = wrgrm_pkg::ST_EMIT;
                end else if (wet_e_reg == '0) begin
                    state_next = wrgrm_pkg::ST_EMIT;
                end else begin
                    state_next = wrgrm_pkg::ST_LOG_NORM;
                end
            wrgrm_pkg::ST_LOG_START: state_next = wrgrm_pkg::ST_LOG_NORM;
            wrgrm_pkg::ST_LOG_NORM:  state_next = wrgrm_pkg::ST_LOG_SQ;
            wrgrm_pkg::ST_LOG_SQ:    state_next = wrgrm_pkg::ST_LOG_STEP;
            wrgrm_pkg::ST_LOG_STEP:
                if (bit_reg != '0) begin
                    state_next = wrgrm_pkg::ST_LOG_SQ;
                end else if (!which_reg) begin
                    state_next = wrgrm_pkg::ST_LOG_START;
                end else begin
                    state_next = wrgrm_pkg::ST_SCALE;
                end
            wrgrm_pkg::ST_SCALE: state_next = wrgrm_pkg::ST_ROUND;
            wrgrm_pkg::ST_ROUND: state_next = wrgrm_pkg::ST_EMIT;
            wrgrm_pkg::ST_EMIT:  state_next = wrgrm_pkg::ST_IDLE;
            default:             state_next = wrgrm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wrgrm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wpos_reg    <= '0;
            seen_reg    <= '0;
            pairs_reg   <= '0;
            dry_e_reg   <= '0;
            wet_e_reg   <= '0;
            nws_reg     <= '0;
            m_valid_reg <= 1'b0;
            which_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                wrgrm_pkg::ST_IDLE:
                    if (accept_in) begin
                        wpos_reg  <= wpos_reg + 1'b1;
                        wet_s_reg <= s_tdata[2*SB-1:SB];
                        if (13'(lat_reg) > seen_reg) begin
                            seen_reg <= seen_reg + 1'b1;
                        end
                    end
                wrgrm_pkg::ST_ACCUM: begin
                    dry_e_reg <= dsum[64] ? '1 : dsum[63:0];
                    wet_e_reg <= wsum[64] ? '1 : wsum[63:0];
                    pairs_reg <= pairs_reg + 1'b1;
                end
                wrgrm_pkg::ST_THRESH:
                    if (!(m_valid_reg && !m_tready)) begin
                        silent_reg <= (dry_e_reg == '0 || dry_e_reg < 64'(thr_prod));
                        gain_reg   <= (dry_e_reg == '0 || dry_e_reg < 64'(thr_prod))
                                      ? '0 : wrgrm_pkg::GainFloor;
                        which_reg  <= 1'b0;
                    end
                wrgrm_pkg::ST_LOG_START: which_reg <= 1'b1;
                wrgrm_pkg::ST_LOG_NORM: begin
                    mant_reg <= norm_m;
                    bit_reg  <= 5'(FB - 1);
                    if (which_reg) begin
                        lg_reg <= {lead, 24'd0};
                    end else begin
                        lw_reg <= {lead, 24'd0};
                    end
                end
                wrgrm_pkg::ST_LOG_SQ:
                    sq_reg <= mant_reg * mant_reg;
                wrgrm_pkg::ST_LOG_STEP: begin
                    bit_reg <= bit_reg - 1'b1;
                    if (sq_reg[63]) begin
                        mant_reg <= sq_reg[63:32];
                        if (which_reg) begin
                            lg_reg[bit_reg] <= 1'b1;
                        end else begin
                            lw_reg[bit_reg] <= 1'b1;
                        end
                    end else begin
                        mant_reg <= sq_reg[62:31];
                    end
                end
                wrgrm_pkg::ST_SCALE:
                    prod_reg <= 49'(ldiff) * $signed(49'(wrgrm_pkg::DbPerOct));
                wrgrm_pkg::ST_ROUND:
                    if (gsig < -19'sd76800) begin
                        gain_reg <= wrgrm_pkg::GainFloor;
                    end else if (gsig > 19'sd32767) begin
                        gain_reg <= wrgrm_pkg::GainCeil;
                    end else begin
                        gain_reg <= gsig[GB_W-1:0];
                    end
                wrgrm_pkg::ST_EMIT: begin
                    m_valid_reg <= 1'b1;
                    m_data_reg  <= {5'd0, silent_reg, nws_reg, gain_reg};
                    nws_reg     <= nws_reg + 32'(pairs_reg);
                    pairs_reg   <= '0;
                    dry_e_reg   <= '0;
                    wet_e_reg   <= '0;
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // A result register is only loaded once the previous word has left.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wrgrm_pkg::ST_EMIT) |-> (!m_valid_reg || m_tready))
        else $error("result overwritten");

    // The pair count never passes the maximum window length at rest.
    a_pairs_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wrgrm_pkg::ST_IDLE) |-> (pairs_reg <= wrgrm_pkg::MaxWindow))
        else $error("pair count out of range");

endmodule

FILE: bench/windowed_rms_gain_reduction_meter_test.sv
// ============================================================================
// windowed_rms_gain_reduction_meter_test: self-checking bench of the meter
// Drives dry/wet sample words, predicts every window result with its own
// model of the delay line, the energy sums and the Q10.7 dB level, and
// compares each result word field by field, under random idling and stalls.
// ============================================================================
module windowed_rms_gain_reduction_meter_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // [23:0] dry_sample, [47:24] wet_sample
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // [17:0] gain_db, [49:18] window_start, [50] silent
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [20:0] cfg_wdata;

    windowed_rms_gain_reduction_meter DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // One expected window report.
    typedef struct packed {
        logic [17:0] gain;
        logic [31:0] start;
        logic        silent;
    } window_report_t;

    window_report_t pending_reports[$];
    int unsigned    error_count = 0;

    // Idling controls: percentage of cycles each side idles, and a counted
    // stretch during which the receiver refuses every word.
    int unsigned sender_gap_pct  = 0;
    int unsigned recv_stall_pct  = 0;
    int unsigned recv_hold_left  = 0;

    // The bench's own copy of the configuration and the meter state.
    logic [16:0] win_reg;
    logic [11:0] lat_reg;
    logic [20:0] thr_reg;
    logic [23:0] dry_history[4096];
    logic [11:0] hist_wr;
    logic [12:0] seen_count;
    logic [16:0] pair_count;
    logic [63:0] dry_sum;
    logic [63:0] wet_sum;
    logic [31:0] start_index;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // A generous ceiling on the whole run; a correct run ends far earlier.
    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // The receiver: a long counted hold-off takes precedence over the random
    // stalls, so the block fills up and has to stall its input.
    always @(posedge aclk) begin
        if (recv_hold_left > 0) begin
            recv_hold_left <= recv_hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker: each accepted word is compared with the oldest report.
    always @(posedge aclk) begin
        window_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, m_tdata);
                error_count++;
            end else begin
                want = pending_reports.pop_front();
                if (m_tdata[17:0] !== want.gain) begin
                    $display("%0t: gain_db expected %0d actual %0d", $time,
                             $signed(want.gain), $signed(m_tdata[17:0]));
                    error_count++;
                end
                if (m_tdata[49:18] !== want.start) begin
                    $display("%0t: window_start expected %0d actual %0d", $time,
                             want.start, m_tdata[49:18]);
                    error_count++;
                end
                if (m_tdata[50] !== want.silent) begin
                    $display("%0t: silent expected %0b actual %0b", $time,
                             want.silent, m_tdata[50]);
                    error_count++;
                end
            end
        end
    end

    function automatic logic [63:0] square_of_sample(logic [23:0] s);
        logic [63:0] mag;
        mag = s[23] ? (64'h100_0000 - {40'd0, s}) : {40'd0, s};
        return mag * mag;
    endfunction

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    // Base-2 logarithm in Q.24: msb position, then one fraction bit per
    // squaring of a Q1.31 mantissa, truncating.
    function automatic longint log2_fixed(logic [63:0] x);
        int          e;
        logic [63:0] m;
        longint      r;
        e = 63;
        while (e > 0 && !x[e]) e--;
        m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
        r = longint'(e) <<< 24;
        for (int i = 23; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
                r = r | (longint'(1) <<< i);
                m = m >> 1;
            end
        end
        return r;
    endfunction

    // Wet over dry level in signed Q10.7 dB, rounded half away from zero, clamped.
    function automatic logic [17:0] level_db(logic [63:0] wet, logic [63:0] dry);
        longint      p;
        logic [63:0] mag;
        longint      g;
        if (wet == 0) return wrgrm_pkg::GainFloor;
        p = (log2_fixed(wet) - log2_fixed(dry)) * 197283;
        mag = (p < 0) ? -p : p;
        g = longint'((mag + 64'h8000_0000) >> 32);
        if (p < 0) g = -g;
        if (g < -76800) g = -76800;
        if (g > 32767) g = 32767;
        return g[17:0];
    endfunction

    // Advances the bench's meter state by one accepted word.
    function automatic void predict_word(logic [23:0] dry, logic [23:0] wet);
        logic [11:0]    lat;
        logic [16:0]    win;
        logic [11:0]    rd;
        logic           quiet;
        window_report_t rep;
        lat = lat_reg;
        win = (win_reg == 0) ? 17'd1 : win_reg;
        if (win > wrgrm_pkg::MaxWindow) win = wrgrm_pkg::MaxWindow;
        dry_history[hist_wr] = dry;
        rd = hist_wr - lat;
        hist_wr = hist_wr + 12'd1;
        if (seen_count < lat) begin
            seen_count++;
            return;
        end
        dry_sum = sat_add(dry_sum, square_of_sample(dry_history[rd]));
        wet_sum = sat_add(wet_sum, square_of_sample(wet));
        pair_count++;
        if (pair_count < win) return;
        quiet = (dry_sum == 0) || (dry_sum < 64'(thr_reg) * 64'(pair_count));
        rep.gain   = quiet ? 18'd0 : level_db(wet_sum, dry_sum);
        rep.start  = start_index;
        rep.silent = quiet;
        pending_reports.insert(pending_reports.size(), rep);
        start_index += 32'(pair_count);
        pair_count = 0;
        dry_sum = 0;
        wet_sum = 0;
    endfunction

    // Sends one sample word, idling first at random, and predicts on accept.
    task automatic send_word(logic [23:0] dry, logic [23:0] wet);
        while ($urandom_range(99) < sender_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {wet, dry};
        do @(posedge aclk); while (!s_tready);
        predict_word(dry, wet);
    endtask

    task automatic finish_burst();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // Registers change only with the block idle: all reports in, and time
    // for a window-end computation whose report may not exist.
    task automatic write_reg(logic [1:0] idx, logic [20:0] value);
        finish_burst();
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            wrgrm_pkg::REG_WINDOW_LEN: win_reg = value[16:0];
            wrgrm_pkg::REG_LATENCY:    lat_reg = value[11:0];
            wrgrm_pkg::REG_SILENCE:    thr_reg = value;
            default: ;
        endcase
    endtask

    function automatic logic [23:0] random_sample();
        case ($urandom_range(5))
            0: return 24'd0;
            1: return 24'($signed($urandom_range(64)) - 32);
            2: return 24'h800000 | 24'($urandom_range(3));
            3: return 24'h7FFFFF - 24'($urandom_range(3));
            default: return 24'($urandom);
        endcase
    endfunction

    // Field extremes, zero energies, saturating gain and silence thresholds.
    task automatic test_level_extremes();
        write_reg(wrgrm_pkg::REG_WINDOW_LEN, 21'd1);
        send_word(24'd0, 24'd1000);             // zero dry energy: silent
        send_word(24'd5000, 24'd0);             // zero wet energy: floor
        send_word(24'h7FFFFF, 24'h7FFFFF);
        send_word(24'h800000, 24'h800000);
        send_word(24'd1, 24'h800000);           // tiny dry energy: silent
        send_word(24'h800000, 24'd1);
        send_word(24'hFFFFFF, 24'h000003);
        write_reg(wrgrm_pkg::REG_SILENCE, 21'd0);       // only zero dry is silent
        send_word(24'd1, 24'd1);
        send_word(24'd0, 24'd0);
        write_reg(wrgrm_pkg::REG_SILENCE, 21'h1FFFFF);  // nearly everything is silent
        send_word(24'd1448, 24'd7);
        send_word(24'h7FFFFF, 24'd7);
        write_reg(wrgrm_pkg::REG_SILENCE, 21'd1048576);
        send_word(24'd1024, 24'd9);
        send_word(24'd1025, 24'd9);
        write_reg(wrgrm_pkg::REG_SILENCE, 21'd70);
    endtask

    // Window length of zero, beyond the maximum, and shortened mid-window.
    task automatic test_window_extremes();
        write_reg(wrgrm_pkg::REG_WINDOW_LEN, 21'd0);
        repeat (3) send_word(random_sample(), random_sample());
        write_reg(wrgrm_pkg::REG_WINDOW_LEN, 21'd65536);
        repeat (6) send_word(random_sample(), random_sample());
        write_reg(wrgrm_pkg::REG_WINDOW_LEN, 21'h1FFFF);
        repeat (4) send_word(random_sample(), random_sample());
        write_reg(wrgrm_pkg::REG_WINDOW_LEN, 21'd3);    // running window closes at once
        repeat (4) send_word(random_sample(), random_sample());
    endtask

    // Latency raised mid-stream, raised far, and back to zero.
    task automatic test_latency();
        write_reg(wrgrm_pkg::REG_WINDOW_LEN, 21'd2);
        write_reg(wrgrm_pkg::REG_LATENCY, 21'd5);
        repeat (12) send_word(random_sample(), random_sample());
        write_reg(wrgrm_pkg::REG_WINDOW_LEN, 21'd97);
        write_reg(wrgrm_pkg::REG_LATENCY, 21'd400);
        repeat (600) send_word(random_sample(), random_sample());
        write_reg(wrgrm_pkg::REG_LATENCY, 21'd0);
        write_reg(wrgrm_pkg::REG_WINDOW_LEN, 21'd4);
        repeat (9) send_word(random_sample(), random_sample());
    endtask

    // A long receiver hold-off while a report comes from every word.
    task automatic test_backpressure();
        write_reg(wrgrm_pkg::REG_WINDOW_LEN, 21'd1);
        recv_hold_left = 400;
        repeat (40) send_word(random_sample(), random_sample());
    endtask

    // Random configurations, mostly short windows, with random content.
    task automatic test_random_phase(int unsigned gap_pct, int unsigned stall_pct);
        logic [23:0] dry;
        sender_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        for (int blk = 0; blk < 6; blk++) begin
            write_reg(wrgrm_pkg::REG_WINDOW_LEN, ($urandom_range(3) == 0) ?
                      21'($urandom_range(9, 64)) : 21'($urandom_range(1, 8)));
            write_reg(wrgrm_pkg::REG_LATENCY, ($urandom_range(3) == 0) ?
                      21'($urandom_range(21, 300)) : 21'($urandom_range(20)));
            write_reg(wrgrm_pkg::REG_SILENCE, ($urandom_range(2) == 0) ?
                      21'($urandom) : 21'($urandom_range(100)));
            repeat (30) begin
                dry = random_sample();
                send_word(dry, ($urandom_range(1) == 0) ? 24'($signed(dry) >>> 2)
                                                      : random_sample());
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = wrgrm_pkg::REG_WINDOW_LEN;
        cfg_wdata = '0;
        win_reg = 17'd480;  lat_reg = '0;  thr_reg = 21'd70;
        hist_wr = '0;  seen_count = '0;  pair_count = '0;
        dry_sum = '0;  wet_sum = '0;  start_index = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_level_extremes();
        test_window_extremes();
        test_latency();
        test_backpressure();
        test_random_phase(11, 66);
        test_random_phase(66, 11);
        test_random_phase(0, 0);

        finish_burst();
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
